@@ hdl/sknt_pkg.sv @@
package sknt_pkg;

    localparam int ENTRIES_DEF       = 15;
    localparam int KEY_WIDTH_DEF     = 32;
    localparam int POINTER_WIDTH_DEF = 32;

    // operation codes
    localparam logic [2:0] KIND_FIND      = 3'd0;
    localparam logic [2:0] KIND_INSERT    = 3'd1;
    localparam logic [2:0] KIND_DELETE    = 3'd2;
    localparam logic [2:0] KIND_OVERWRITE = 3'd3;
    localparam logic [2:0] KIND_READ      = 3'd4;
    localparam logic [2:0] KIND_BRANCH    = 3'd5;

    // result status codes
    localparam logic [2:0] ST_DONE   = 3'd0;
    localparam logic [2:0] ST_MATCH  = 3'd1;
    localparam logic [2:0] ST_ABOVE  = 3'd2;
    localparam logic [2:0] ST_BELOW  = 3'd3;
    localparam logic [2:0] ST_REJECT = 3'd4;

    // location code for the left child
    localparam logic [4:0] LOC_LEFT = 5'h1F;

    // command broadcast to every cell of the row
    typedef struct packed {
        logic       fire;
        logic       look;
        logic [2:0] kind;
        logic [3:0] loc;
    } cell_cmd_t;

endpackage

@@ hdl/sknt_cell.sv @@
module sknt_cell #(
    parameter int KEY_WIDTH     = sknt_pkg::KEY_WIDTH_DEF,
    parameter int POINTER_WIDTH = sknt_pkg::POINTER_WIDTH_DEF,
    parameter int INDEX         = 0
) (
    input  logic                     aclk,
    input  sknt_pkg::cell_cmd_t      cmd,
    input  logic                     live,
    input  logic [KEY_WIDTH-1:0]     new_key,
    input  logic [POINTER_WIDTH-1:0] new_child,
    input  logic [KEY_WIDTH-1:0]     lo_key,
    input  logic [POINTER_WIDTH-1:0] lo_child,
    input  logic [KEY_WIDTH-1:0]     hi_key,
    input  logic [POINTER_WIDTH-1:0] hi_child,
    output logic [KEY_WIDTH-1:0]     key,
    output logic [POINTER_WIDTH-1:0] child,
    output logic                     hit,
    output logic                     eq
);

    logic [KEY_WIDTH-1:0]     key_reg, key_next;
    logic [POINTER_WIDTH-1:0] child_reg, child_next;
    logic                     hit_reg, hit_next;
    logic                     eq_reg, eq_next;
    logic                     at_loc, above_loc;

    assign at_loc    = (INDEX == int'(cmd.loc));
    assign above_loc = (INDEX > int'(cmd.loc));

    always_comb begin
        key_next   = key_reg;
        child_next = child_reg;
        hit_next   = hit_reg;
        eq_next    = eq_reg;
        if (cmd.look) begin
            hit_next = live && (key_reg <= new_key);
            eq_next  = (key_reg == new_key);
        end
        if (cmd.fire) begin
            case (cmd.kind)
                sknt_pkg::KIND_INSERT: begin
                    // open a gap at the location, push the rest up one cell
                    if (at_loc) begin
                        key_next   = new_key;
                        child_next = new_child;
                    end else if (above_loc) begin
                        key_next   = lo_key;
                        child_next = lo_child;
                    end
                end
                sknt_pkg::KIND_DELETE: begin
                    if (at_loc || above_loc) begin
                        key_next   = hi_key;
                        child_next = hi_child;
                    end
                end
                sknt_pkg::KIND_OVERWRITE: begin
                    if (at_loc) begin
                        key_next   = new_key;
                        child_next = new_child;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        key_reg   <= key_next;
        child_reg <= child_next;
        hit_reg   <= hit_next;
        eq_reg    <= eq_next;
    end

    assign key   = key_reg;
    assign child = child_reg;
    assign hit   = hit_reg;
    assign eq    = eq_reg;

endmodule

@@ hdl/sknt_seek.sv @@
module sknt_seek #(
    parameter int ENTRIES = sknt_pkg::ENTRIES_DEF
) (
    input  logic [ENTRIES-1:0]         hit,
    input  logic [ENTRIES-1:0]         eq,
    output logic                       found,
    output logic                       exact,
    output logic [$clog2(ENTRIES)-1:0] index
);

    localparam int IW = $clog2(ENTRIES);

    // highest flagged cell wins
    always_comb begin
        found = 1'b0;
        exact = 1'b0;
        index = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (hit[i]) begin
                found = 1'b1;
                exact = eq[i];
                index = IW'(i);
            end
        end
    end

endmodule

@@ hdl/sorted_key_node_table_unit.sv @@
// Channel   Ports                                          Direction
// s_        s_valid s_ready s_kind s_key s_child s_location  in, one op per beat
// m_        m_valid m_ready m_status m_found_location
//           m_out_key m_out_child m_entry_total           out, one result per beat
// cfg_      cfg_we cfg_wdata                                in, left child pointer
//
// For each operation, at the accepting edge the row of cells shifts or writes and
// latches its compare flags, then the response stage priority-encodes those flags
// and loads the output register. The count and the left pointer reset to zero;
// the cells hold no reset. A result waiting on m_ready does not block the next
// beat on s_; that beat waits in the response stage until the output frees.
module sorted_key_node_table_unit #(
    parameter int ENTRIES       = sknt_pkg::ENTRIES_DEF,
    parameter int KEY_WIDTH     = sknt_pkg::KEY_WIDTH_DEF,
    parameter int POINTER_WIDTH = sknt_pkg::POINTER_WIDTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [31:0]       cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [2:0]        s_kind,
    input  logic [31:0]       s_key,
    input  logic [31:0]       s_child,
    input  logic signed [4:0] s_location,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [2:0]        m_status,
    output logic signed [4:0] m_found_location,
    output logic [31:0]       m_out_key,
    output logic [31:0]       m_out_child,
    output logic [3:0]        m_entry_total
);

    localparam int CW = $clog2(ENTRIES + 1);
    localparam int LW = (CW > 4) ? CW : 4;
    localparam int IW = $clog2(ENTRIES);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RESP = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0]            count_reg, count_next;
    logic [POINTER_WIDTH-1:0] left_reg, left_next;

    logic                     rsp_find_reg, rsp_find_next;
    logic [2:0]               rsp_status_reg, rsp_status_next;
    logic [KEY_WIDTH-1:0]     rsp_key_reg, rsp_key_next;
    logic [POINTER_WIDTH-1:0] rsp_child_reg, rsp_child_next;
    logic [3:0]               rsp_total_reg, rsp_total_next;

    logic                     m_valid_reg, m_valid_next;
    logic [2:0]               m_status_reg, m_status_next;
    logic [4:0]               m_found_reg, m_found_next;
    logic [31:0]              m_key_reg, m_key_next;
    logic [31:0]              m_child_reg, m_child_next;
    logic [3:0]               m_total_reg, m_total_next;

    logic [KEY_WIDTH+31:0]     key_wide;
    logic [POINTER_WIDTH+31:0] child_wide, cfg_wide;
    logic [KEY_WIDTH-1:0]      key_in;
    logic [POINTER_WIDTH-1:0]  child_in;

    logic [KEY_WIDTH-1:0]     key_q   [ENTRIES];
    logic [POINTER_WIDTH-1:0] child_q [ENTRIES];
    logic [ENTRIES-1:0]       hit_v, eq_v, live_v;

    logic                     accept, op_ok, loc_neg, in_lt, in_le, not_full, is_left;
    logic [3:0]               loc_u;
    logic [LW-1:0]            loc_x, cnt_x;
    logic [KEY_WIDTH-1:0]     sel_key;
    logic [POINTER_WIDTH-1:0] sel_child;
    logic [CW+3:0]            total_wide;
    sknt_pkg::cell_cmd_t      cmd;

    logic                     seek_found, seek_exact;
    logic [IW-1:0]            seek_index;
    logic [IW+4:0]            seek_wide;
    logic [KEY_WIDTH+31:0]    okey_wide;
    logic [POINTER_WIDTH+31:0] ochild_wide;

    // keep the payload to the configured widths
    assign key_wide   = {{KEY_WIDTH{1'b0}}, s_key};
    assign child_wide = {{POINTER_WIDTH{1'b0}}, s_child};
    assign cfg_wide   = {{POINTER_WIDTH{1'b0}}, cfg_wdata};
    assign key_in     = key_wide[KEY_WIDTH-1:0];
    assign child_in   = child_wide[POINTER_WIDTH-1:0];

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign loc_neg  = s_location[4];
    assign loc_u    = s_location[3:0];
    assign loc_x    = LW'(loc_u);
    assign cnt_x    = LW'(count_reg);
    assign in_lt    = !loc_neg && (loc_x < cnt_x);
    assign in_le    = !loc_neg && (loc_x <= cnt_x);
    assign not_full = (count_reg != CW'(ENTRIES));
    assign is_left  = ($unsigned(s_location) == sknt_pkg::LOC_LEFT);

    always_comb begin
        sel_key   = '0;
        sel_child = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (loc_x == LW'(i)) begin
                sel_key   = key_q[i];
                sel_child = child_q[i];
            end
        end
    end

    always_comb begin
        case (s_kind)
            sknt_pkg::KIND_FIND:      op_ok = 1'b1;
            sknt_pkg::KIND_INSERT:    op_ok = in_le && not_full;
            sknt_pkg::KIND_DELETE,
            sknt_pkg::KIND_OVERWRITE,
            sknt_pkg::KIND_READ:      op_ok = in_lt;
            sknt_pkg::KIND_BRANCH:    op_ok = is_left || in_lt;
            default:                  op_ok = 1'b0;
        endcase
    end

    assign cmd.fire = accept && op_ok;
    assign cmd.look = accept && (s_kind == sknt_pkg::KIND_FIND);
    assign cmd.kind = s_kind;
    assign cmd.loc  = loc_u;

    always_comb begin
        count_next = count_reg;
        if (cmd.fire && (s_kind == sknt_pkg::KIND_INSERT)) begin
            count_next = count_reg + CW'(1);
        end else if (cmd.fire && (s_kind == sknt_pkg::KIND_DELETE)) begin
            count_next = count_reg - CW'(1);
        end
    end

    assign total_wide = {4'b0, count_next};
    assign left_next  = cfg_we ? cfg_wide[POINTER_WIDTH-1:0] : left_reg;

    // latch the non-find part of the result at the accepting edge
    always_comb begin
        rsp_find_next   = rsp_find_reg;
        rsp_status_next = rsp_status_reg;
        rsp_key_next    = rsp_key_reg;
        rsp_child_next  = rsp_child_reg;
        rsp_total_next  = rsp_total_reg;
        if (accept) begin
            rsp_find_next   = (s_kind == sknt_pkg::KIND_FIND);
            rsp_status_next = op_ok ? sknt_pkg::ST_DONE : sknt_pkg::ST_REJECT;
            rsp_key_next    = '0;
            rsp_child_next  = '0;
            rsp_total_next  = total_wide[3:0];
            if (op_ok && (s_kind == sknt_pkg::KIND_READ)) begin
                rsp_key_next   = sel_key;
                rsp_child_next = sel_child;
            end else if (op_ok && (s_kind == sknt_pkg::KIND_BRANCH)) begin
                rsp_child_next = is_left ? left_reg : sel_child;
            end
        end
    end

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        logic [KEY_WIDTH-1:0]     lo_key, hi_key;
        logic [POINTER_WIDTH-1:0] lo_child, hi_child;

        if (g == 0) begin : g_lo_edge
            assign lo_key   = key_in;
            assign lo_child = child_in;
        end else begin : g_lo_link
            assign lo_key   = key_q[g-1];
            assign lo_child = child_q[g-1];
        end

        if (g == ENTRIES - 1) begin : g_hi_edge
            assign hi_key   = key_q[g];
            assign hi_child = child_q[g];
        end else begin : g_hi_link
            assign hi_key   = key_q[g+1];
            assign hi_child = child_q[g+1];
        end

        assign live_v[g] = (cnt_x > LW'(g));

        sknt_cell #(
            .KEY_WIDTH     (KEY_WIDTH),
            .POINTER_WIDTH (POINTER_WIDTH),
            .INDEX         (g)
        ) u_cell (
            .aclk      (aclk),
            .cmd       (cmd),
            .live      (live_v[g]),
            .new_key   (key_in),
            .new_child (child_in),
            .lo_key    (lo_key),
            .lo_child  (lo_child),
            .hi_key    (hi_key),
            .hi_child  (hi_child),
            .key       (key_q[g]),
            .child     (child_q[g]),
            .hit       (hit_v[g]),
            .eq        (eq_v[g])
        );
    end

    sknt_seek #(
        .ENTRIES (ENTRIES)
    ) u_seek (
        .hit   (hit_v),
        .eq    (eq_v),
        .found (seek_found),
        .exact (seek_exact),
        .index (seek_index)
    );

    assign seek_wide   = {5'b0, seek_index};
    assign okey_wide   = {32'b0, rsp_key_reg};
    assign ochild_wide = {32'b0, rsp_child_reg};

    always_comb begin
        state_next    = state_reg;
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_found_next  = m_found_reg;
        m_key_next    = m_key_reg;
        m_child_next  = m_child_reg;
        m_total_next  = m_total_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_key_next    = okey_wide[31:0];
                    m_child_next  = ochild_wide[31:0];
                    m_total_next  = rsp_total_reg;
                    m_status_next = rsp_status_reg;
                    m_found_next  = '0;
                    if (rsp_find_reg) begin
                        if (seek_found) begin
                            m_status_next = seek_exact ? sknt_pkg::ST_MATCH
                                                       : sknt_pkg::ST_ABOVE;
                            m_found_next  = seek_wide[4:0];
                        end else begin
                            m_status_next = sknt_pkg::ST_BELOW;
                            m_found_next  = sknt_pkg::LOC_LEFT;
                        end
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            left_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            left_reg    <= left_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rsp_find_reg   <= rsp_find_next;
        rsp_status_reg <= rsp_status_next;
        rsp_key_reg    <= rsp_key_next;
        rsp_child_reg  <= rsp_child_next;
        rsp_total_reg  <= rsp_total_next;
        m_status_reg   <= m_status_next;
        m_found_reg    <= m_found_next;
        m_key_reg      <= m_key_next;
        m_child_reg    <= m_child_next;
        m_total_reg    <= m_total_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_found_location = $signed(m_found_reg);
    assign m_out_key        = m_key_reg;
    assign m_out_child      = m_child_reg;
    assign m_entry_total    = m_total_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(ENTRIES))
        else $error("entry count above node size");

    a_accept_to_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == S_RESP))
        else $error("accepted beat did not reach response stage");

    a_reject_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == sknt_pkg::ST_REJECT)) |->
        ((m_found_location == 5'sd0) && (m_out_key == 32'd0) && (m_out_child == 32'd0)))
        else $error("rejected result carries data");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(count_reg))
        else $error("entry count moved without an operation");
`endif

endmodule
